// ===== src/lrdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrdc_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int HDR_IDX_W = 5;
   localparam int KEY_LEN_W = 32;
   localparam int VAL_LEN_W = 32;
   localparam int TS_W = 64;
   localparam int CRC_W = 32;
   localparam int SEEN_W = 33;
   localparam int CONSUMED_W = 34;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_OK        = 2'd0,
      VERDICT_HDR_TRUNC = 2'd1,
      VERDICT_PAY_TRUNC = 2'd2,
      VERDICT_CRC_BAD   = 2'd3
   } verdict_type;

   typedef struct packed {
      logic                  has_payload;
      logic [7:0]            payload_byte;
      logic                  in_value_part;
      logic                  has_verdict;
      verdict_type           verdict;
      logic [TS_W-1:0]       record_timestamp;
      logic [KEY_LEN_W-1:0]  key_length;
      logic [VAL_LEN_W-1:0]  value_length;
      logic [CONSUMED_W-1:0] consumed_bytes;
   } cmd_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [7:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/lrdc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrdc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire logic [7:0]      req_data_byte,
   input  wire logic            req_end_of_data,
   output logic                 cmd_wr,
   output lrdc_pkg::cmd_type    cmd,
   input  wire logic            queue_full
);
   import lrdc_pkg::*;

   logic [HDR_IDX_W-1:0] header_index_ff, header_index_in;
   logic [TS_W-1:0]      timestamp_ff, timestamp_in;
   logic [KEY_LEN_W-1:0] key_len_ff, key_len_in;
   logic [VAL_LEN_W-1:0] value_len_ff, value_len_in;
   logic [CRC_W-1:0]     stored_crc_ff, stored_crc_in;
   logic [CRC_W-1:0]     running_crc_ff, running_crc_in;
   logic [SEEN_W-1:0]    payload_seen_ff, payload_seen_in;

   logic                 accept;
   logic                 in_header;
   logic [SEEN_W-1:0]    total;
   logic                 clear;
   logic [5:0]           ts_shift;
   logic [4:0]           word_shift;

   assign full      = queue_full;
   assign accept    = push && !queue_full;
   assign in_header = header_index_ff < HDR_IDX_W'(HEADER_BYTES);
   assign ts_shift  = {header_index_ff[2:0], 3'b000};
   assign word_shift = {header_index_ff[1:0], 3'b000};

   always_comb begin
      header_index_in = header_index_ff;
      timestamp_in    = timestamp_ff;
      key_len_in      = key_len_ff;
      value_len_in    = value_len_ff;
      stored_crc_in   = stored_crc_ff;
      running_crc_in  = running_crc_ff;
      payload_seen_in = payload_seen_ff;
      total           = {1'b0, key_len_ff} + {1'b0, value_len_ff};
      clear           = 1'b0;
      cmd             = '0;

      if (accept) begin
         if (in_header) begin
            if (header_index_ff < HDR_IDX_W'(8)) begin
               timestamp_in = timestamp_ff | (TS_W'(req_data_byte) << ts_shift);
            end else if (header_index_ff < HDR_IDX_W'(12)) begin
               key_len_in = key_len_ff | (KEY_LEN_W'(req_data_byte) << word_shift);
            end else if (header_index_ff < HDR_IDX_W'(16)) begin
               value_len_in = value_len_ff | (VAL_LEN_W'(req_data_byte) << word_shift);
            end else begin
               stored_crc_in = stored_crc_ff | (CRC_W'(req_data_byte) << word_shift);
            end
            if (header_index_ff < HDR_IDX_W'(16)) begin
               running_crc_in = crc_byte(running_crc_ff, req_data_byte);
            end
            header_index_in = header_index_ff + 1'b1;
            total = {1'b0, key_len_in} + {1'b0, value_len_in};

            if (header_index_in == HDR_IDX_W'(HEADER_BYTES) && total == '0) begin
               cmd.has_verdict      = 1'b1;
               cmd.verdict          = ((running_crc_in ^ CRC_INIT) == stored_crc_in)
                                      ? VERDICT_OK : VERDICT_CRC_BAD;
               cmd.record_timestamp = timestamp_in;
               cmd.key_length       = key_len_in;
               cmd.value_length     = value_len_in;
               cmd.consumed_bytes   = CONSUMED_W'(HEADER_BYTES);
               clear                = 1'b1;
            end else if (req_end_of_data) begin
               cmd.has_verdict = 1'b1;
               if (header_index_in < HDR_IDX_W'(HEADER_BYTES)) begin
                  cmd.verdict = VERDICT_HDR_TRUNC;
               end else begin
                  cmd.verdict          = VERDICT_PAY_TRUNC;
                  cmd.record_timestamp = timestamp_in;
                  cmd.key_length       = key_len_in;
                  cmd.value_length     = value_len_in;
               end
               clear = 1'b1;
            end
         end else begin
            cmd.has_payload   = 1'b1;
            cmd.payload_byte  = req_data_byte;
            cmd.in_value_part = payload_seen_ff >= {1'b0, key_len_ff};
            running_crc_in    = crc_byte(running_crc_ff, req_data_byte);
            payload_seen_in   = payload_seen_ff + 1'b1;

            if (payload_seen_in >= total) begin
               cmd.has_verdict      = 1'b1;
               cmd.verdict          = ((running_crc_in ^ CRC_INIT) == stored_crc_ff)
                                      ? VERDICT_OK : VERDICT_CRC_BAD;
               cmd.record_timestamp = timestamp_ff;
               cmd.key_length       = key_len_ff;
               cmd.value_length     = value_len_ff;
               cmd.consumed_bytes   = CONSUMED_W'(HEADER_BYTES) + CONSUMED_W'(total);
               clear                = 1'b1;
            end else if (req_end_of_data) begin
               cmd.has_verdict      = 1'b1;
               cmd.verdict          = VERDICT_PAY_TRUNC;
               cmd.record_timestamp = timestamp_ff;
               cmd.key_length       = key_len_ff;
               cmd.value_length     = value_len_ff;
               clear                = 1'b1;
            end
         end
      end

      if (clear) begin
         header_index_in = '0;
         timestamp_in    = '0;
         key_len_in      = '0;
         value_len_in    = '0;
         stored_crc_in   = '0;
         running_crc_in  = CRC_INIT;
         payload_seen_in = '0;
      end
   end

   assign cmd_wr = accept && (cmd.has_payload || cmd.has_verdict);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff <= '0;
         timestamp_ff    <= '0;
         key_len_ff      <= '0;
         value_len_ff    <= '0;
         stored_crc_ff   <= '0;
         running_crc_ff  <= CRC_INIT;
         payload_seen_ff <= '0;
      end else begin
         header_index_ff <= header_index_in;
         timestamp_ff    <= timestamp_in;
         key_len_ff      <= key_len_in;
         value_len_ff    <= value_len_in;
         stored_crc_ff   <= stored_crc_in;
         running_crc_ff  <= running_crc_in;
         payload_seen_ff <= payload_seen_in;
      end
   end

`ifndef SYNTHESIS
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      header_index_ff <= HDR_IDX_W'(HEADER_BYTES))
      else $error("header index out of range");
   a_seen_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      in_header |-> payload_seen_ff == '0)
      else $error("payload count nonzero in header");
   a_no_header_overflow: assert property (@(posedge clock) disable iff (reset)
      (accept && in_header && header_index_ff == HDR_IDX_W'(HEADER_BYTES - 1))
      |=> !in_header || header_index_ff == '0)
      else $error("header did not complete");
`endif

endmodule

`default_nettype wire

// ===== src/lrdc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrdc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire lrdc_pkg::cmd_type wr_cmd,
   output logic                  queue_full,
   input  wire logic             rd_en,
   output lrdc_pkg::cmd_type     rd_cmd,
   output logic                  head_valid
);
   import lrdc_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign queue_full = count_ff == QUEUE_CW'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign rd_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !queue_full)
      else $error("write into full queue");
   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> head_valid)
      else $error("read from empty queue");
`endif

endmodule

`default_nettype wire

// ===== src/lrdc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrdc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire lrdc_pkg::cmd_type head,
   output logic                   head_done,
   output logic                   empty,
   input  wire logic              pop,
   output logic                   rsp_item_kind,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_in_value_part,
   output logic [1:0]             rsp_verdict,
   output logic [63:0]            rsp_record_timestamp,
   output logic [31:0]            rsp_key_length,
   output logic [31:0]            rsp_value_length,
   output logic [33:0]            rsp_consumed_bytes
);
   import lrdc_pkg::*;

   logic                  out_valid_ff, out_valid_in;
   logic                  second_ff, second_in;
   logic                  load;
   logic                  emit;
   logic                  emit_payload;

   logic                  kind_ff;
   logic [7:0]            byte_ff;
   logic                  value_part_ff;
   verdict_type           verdict_ff;
   logic [TS_W-1:0]       ts_ff;
   logic [KEY_LEN_W-1:0]  key_len_ff;
   logic [VAL_LEN_W-1:0]  value_len_ff;
   logic [CONSUMED_W-1:0] consumed_ff;

   assign load         = !out_valid_ff || pop;
   assign emit         = load && head_valid;
   assign emit_payload = head.has_payload && !second_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      second_in    = second_ff;
      head_done    = 1'b0;
      if (load) begin
         out_valid_in = head_valid;
      end
      if (emit) begin
         if (emit_payload && head.has_verdict) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            head_done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (emit_payload) begin
            kind_ff       <= ITEM_PAYLOAD;
            byte_ff       <= head.payload_byte;
            value_part_ff <= head.in_value_part;
            verdict_ff    <= VERDICT_OK;
            ts_ff         <= '0;
            key_len_ff    <= '0;
            value_len_ff  <= '0;
            consumed_ff   <= '0;
         end else begin
            kind_ff       <= ITEM_VERDICT;
            byte_ff       <= '0;
            value_part_ff <= 1'b0;
            verdict_ff    <= head.verdict;
            ts_ff         <= head.record_timestamp;
            key_len_ff    <= head.key_length;
            value_len_ff  <= head.value_length;
            consumed_ff   <= head.consumed_bytes;
         end
      end
   end

   assign empty                = !out_valid_ff;
   assign rsp_item_kind        = kind_ff;
   assign rsp_payload_byte     = byte_ff;
   assign rsp_in_value_part    = value_part_ff;
   assign rsp_verdict          = verdict_ff;
   assign rsp_record_timestamp = ts_ff;
   assign rsp_key_length       = key_len_ff;
   assign rsp_value_length     = value_len_ff;
   assign rsp_consumed_bytes   = consumed_ff;

`ifndef SYNTHESIS
   a_second_has_verdict: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid && head.has_verdict && head.has_payload)
      else $error("verdict half pending without entry");
   a_payload_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && kind_ff == ITEM_PAYLOAD) |-> consumed_ff == '0 && ts_ff == '0)
      else $error("payload item carries verdict fields");
   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> out_valid_ff && $stable(kind_ff) && $stable(second_ff))
      else $error("stalled item changed");
`endif

endmodule

`default_nettype wire

// ===== src/log_record_decoder_checker_top.sv =====
// record stream checker: 20-byte header, key and value payload, crc-32 verdict
// input queue side: one stream byte per item on req_data_byte, with
//   req_end_of_data marking the last available byte; push while full is low
// result queue side: while empty is low the oldest result is on the rsp_ ports;
//   pop takes it; a payload byte gives one item, the last payload byte gives
//   the payload item and then the verdict item
// path: a byte's result passes from the front through the command queue into
//   the output register; a trailing verdict item follows its payload item
// throughput: one byte per cycle while full is low; the back end emits one item
//   per cycle while the receiver pops, so the extra verdict item of a record's
//   closing byte is absorbed by the 4-entry command queue between front and back
// full rises only when the command queue is full, which happens only when
//   the receiver holds pop low
// reset clears the parser to expect the first header byte of a record and
//   empties the queue and the output register
// a stalled receiver holds the current result; the front keeps taking bytes
//   until the queue fills
`timescale 1ns / 1ps
`default_nettype none

module log_record_decoder_checker_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_data,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_in_value_part,
   output logic [1:0]       rsp_verdict,
   output logic [63:0]      rsp_record_timestamp,
   output logic [31:0]      rsp_key_length,
   output logic [31:0]      rsp_value_length,
   output logic [33:0]      rsp_consumed_bytes
);
   import lrdc_pkg::*;

   logic    cmd_wr;
   cmd_type cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head;
   logic    head_done;

   lrdc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .cmd_wr          (cmd_wr),
      .cmd             (cmd),
      .queue_full      (queue_full)
   );

   lrdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (cmd_wr),
      .wr_cmd     (cmd),
      .queue_full (queue_full),
      .rd_en      (head_done),
      .rd_cmd     (head),
      .head_valid (head_valid)
   );

   lrdc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head                 (head),
      .head_done            (head_done),
      .empty                (empty),
      .pop                  (pop),
      .rsp_item_kind        (rsp_item_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_in_value_part    (rsp_in_value_part),
      .rsp_verdict          (rsp_verdict),
      .rsp_record_timestamp (rsp_record_timestamp),
      .rsp_key_length       (rsp_key_length),
      .rsp_value_length     (rsp_value_length),
      .rsp_consumed_bytes   (rsp_consumed_bytes)
   );

endmodule

`default_nettype wire

// ===== bench/lrdc_stream_monitor.sv =====
`timescale 1ns / 1ps

module lrdc_stream_monitor (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic                  full,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_end_of_data,
   input  wire logic                  empty,
   input  wire logic                  pop,
   input  wire logic                  rsp_item_kind,
   input  wire logic [7:0]            rsp_payload_byte,
   input  wire logic                  rsp_in_value_part,
   input  wire logic [1:0]            rsp_verdict,
   input  wire logic [63:0]           rsp_record_timestamp,
   input  wire logic [31:0]           rsp_key_length,
   input  wire logic [31:0]           rsp_value_length,
   input  wire logic [33:0]           rsp_consumed_bytes,
   output int unsigned                mismatches,
   output int unsigned                pending
);
   import lrdc_pkg::*;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            data;
      logic                  in_value;
      verdict_type           verdict;
      logic [TS_W-1:0]       stamp;
      logic [KEY_LEN_W-1:0]  klen;
      logic [VAL_LEN_W-1:0]  vlen;
      logic [CONSUMED_W-1:0] consumed;
   } rsp_item_type;

   rsp_item_type due_items [$];

   logic [HDR_IDX_W-1:0]  hdr_count;
   logic [TS_W-1:0]       ts_acc;
   logic [KEY_LEN_W-1:0]  klen_acc;
   logic [VAL_LEN_W-1:0]  vlen_acc;
   logic [CRC_W-1:0]      crc_stored;
   logic [CRC_W-1:0]      crc_acc;
   logic [SEEN_W-1:0]     seen_cnt;

   // bit-serial form of the reflected crc-32
   function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] c,
                                                   input logic [7:0] d);
      logic [CRC_W-1:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ d[i]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic rsp_item_type verdict_item(input verdict_type v, input logic with_hdr,
                                                 input logic [CONSUMED_W-1:0] used);
      rsp_item_type it;
      it = '0;
      it.kind = ITEM_VERDICT;
      it.verdict = v;
      if (with_hdr) begin
         it.stamp = ts_acc;
         it.klen = klen_acc;
         it.vlen = vlen_acc;
      end
      it.consumed = used;
      return it;
   endfunction

   task automatic queue_item(input rsp_item_type it);
      due_items.insert(due_items.size(), it);
   endtask

   task automatic clear_record();
      hdr_count = '0;
      ts_acc = '0;
      klen_acc = '0;
      vlen_acc = '0;
      crc_stored = '0;
      crc_acc = CRC_INIT;
      seen_cnt = '0;
   endtask

   task automatic close_record(input logic [SEEN_W-1:0] total);
      verdict_type v;
      v = ((crc_acc ^ CRC_INIT) == crc_stored) ? VERDICT_OK : VERDICT_CRC_BAD;
      queue_item(verdict_item(v, 1'b1, CONSUMED_W'(HEADER_BYTES) + CONSUMED_W'(total)));
      clear_record();
   endtask

   task automatic take_byte(input logic [7:0] d, input logic last);
      logic [SEEN_W-1:0] total;
      rsp_item_type it;
      int idx;
      idx = hdr_count;
      if (idx < HEADER_BYTES) begin
         if (idx < 8) begin
            ts_acc[8*idx +: 8] = d;
         end else if (idx < 12) begin
            klen_acc[8*(idx-8) +: 8] = d;
         end else if (idx < 16) begin
            vlen_acc[8*(idx-12) +: 8] = d;
         end else begin
            crc_stored[8*(idx-16) +: 8] = d;
         end
         if (idx < 16) begin
            crc_acc = crc32_step(crc_acc, d);
         end
         hdr_count = hdr_count + 1'b1;
         total = {1'b0, klen_acc} + {1'b0, vlen_acc};
         if (hdr_count == HEADER_BYTES && total == 0) begin
            close_record(total);
         end else if (last) begin
            if (hdr_count < HEADER_BYTES) begin
               queue_item(verdict_item(VERDICT_HDR_TRUNC, 1'b0, '0));
            end else begin
               queue_item(verdict_item(VERDICT_PAY_TRUNC, 1'b1, '0));
            end
            clear_record();
         end
      end else begin
         total = {1'b0, klen_acc} + {1'b0, vlen_acc};
         it = '0;
         it.kind = ITEM_PAYLOAD;
         it.data = d;
         it.in_value = (seen_cnt >= {1'b0, klen_acc});
         queue_item(it);
         crc_acc = crc32_step(crc_acc, d);
         seen_cnt = seen_cnt + 1'b1;
         if (seen_cnt >= total) begin
            close_record(total);
         end else if (last) begin
            queue_item(verdict_item(VERDICT_PAY_TRUNC, 1'b1, '0));
            clear_record();
         end
      end
   endtask

   task automatic flag_mismatch(input string what);
      $display("at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         flag_mismatch($sformatf("%s mismatch, got %h, expected %h", name, got, want));
      end
   endtask

   task automatic check_item();
      rsp_item_type want;
      if (due_items.size() == 0) begin
         flag_mismatch("item arrived with none expected");
      end else begin
         want = due_items.pop_front();
         check_field("item_kind", want.kind, rsp_item_kind);
         check_field("payload_byte", want.data, rsp_payload_byte);
         check_field("in_value_part", want.in_value, rsp_in_value_part);
         check_field("verdict", want.verdict, rsp_verdict);
         check_field("record_timestamp", want.stamp, rsp_record_timestamp);
         check_field("key_length", want.klen, rsp_key_length);
         check_field("value_length", want.vlen, rsp_value_length);
         check_field("consumed_bytes", want.consumed, rsp_consumed_bytes);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_record();
         due_items.delete();
         mismatches = 0;
      end else begin
         if (push && !full) begin
            take_byte(req_data_byte, req_end_of_data);
         end
         if (pop && !empty) begin
            check_item();
         end
      end
      pending = due_items.size();
   end

endmodule

// ===== bench/tb_log_record_decoder_checker_top.sv =====
`timescale 1ns / 1ps

module tb_log_record_decoder_checker_top;
   import lrdc_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_BYTES = 90;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_data_byte;
   logic        req_end_of_data;
   logic        empty;
   logic        pop;
   logic        rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_in_value_part;
   logic [1:0]  rsp_verdict;
   logic [63:0] rsp_record_timestamp;
   logic [31:0] rsp_key_length;
   logic [31:0] rsp_value_length;
   logic [33:0] rsp_consumed_bytes;

   int unsigned mismatches;
   int unsigned pending;
   int          send_idle;
   int          pop_stall;
   int          bytes_sent;
   int          quiet_cycles;

   log_record_decoder_checker_top DUT (.*);

   lrdc_stream_monitor monitor (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      pop = 1'b0;
      forever begin
         @(posedge clock);
         pop <= ($urandom_range(99) >= pop_stall);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // byte-wise crc-32 used to build well-formed records
   function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c ^ {24'd0, d};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] d, input logic last);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= d;
      req_end_of_data <= last;
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   // stop_after of zero sends the whole record
   task automatic send_record(input logic [63:0] stamp, input logic [31:0] klen,
                              input logic [31:0] vlen, input longint stop_after,
                              input bit flag_last, input bit corrupt);
      logic [7:0]  hdr [20];
      logic [7:0]  body [$];
      logic [31:0] crc;
      longint      full_len;
      longint      n;
      full_len = 20 + 64'(klen) + 64'(vlen);
      n = (stop_after > 0 && stop_after < full_len) ? stop_after : full_len;
      for (int i = 0; i < 8; i++) begin
         hdr[i] = stamp[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         hdr[8+i] = klen[8*i +: 8];
         hdr[12+i] = vlen[8*i +: 8];
      end
      for (longint i = 20; i < n; i++) begin
         body.insert(body.size(), 8'($urandom_range(255)));
      end
      crc = CRC_INIT;
      for (int i = 0; i < 16; i++) begin
         crc = crc32_next(crc, hdr[i]);
      end
      foreach (body[i]) begin
         crc = crc32_next(crc, body[i]);
      end
      crc = ~crc;
      if (corrupt) begin
         crc = crc ^ (32'h1 << $urandom_range(31));
      end
      for (int i = 0; i < 4; i++) begin
         hdr[16+i] = crc[8*i +: 8];
      end
      for (longint i = 0; i < n; i++) begin
         send_byte((i < 20) ? hdr[i] : body[i-20], flag_last && (i == n - 1));
      end
   endtask

   // random bytes, always closed by end of data so the parser resyncs
   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(8'($urandom_range(255)), (i == count - 1) || ($urandom_range(7) == 0));
      end
   endtask

   function automatic logic [31:0] pick_length(input int cap);
      return ($urandom_range(9) == 0) ? 32'($urandom_range(cap * 6)) : 32'($urandom_range(cap));
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int          target;
      int          pick;
      logic [31:0] klen;
      logic [31:0] vlen;
      longint      full_len;
      longint      cap;
      send_idle = idle_pct;
      pop_stall = stall_pct;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            klen = pick_length(5);
            vlen = pick_length(8);
            send_record({$urandom, $urandom}, klen, vlen, 0,
                        $urandom_range(9) == 0, $urandom_range(6) == 0);
         end else if (pick < 88) begin
            klen = $urandom_range(1) ? $urandom : 32'($urandom_range(12));
            vlen = $urandom_range(1) ? $urandom : 32'($urandom_range(12));
            full_len = 20 + 64'(klen) + 64'(vlen);
            cap = (full_len < 48) ? full_len : 48;
            send_record({$urandom, $urandom}, klen, vlen, $urandom_range(int'(cap), 1),
                        1'b1, 1'($urandom_range(1)));
         end else begin
            send_noise($urandom_range(30, 1));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_data_byte = 8'd0;
      req_end_of_data = 1'b0;
      send_idle = 0;
      pop_stall = 0;
      bytes_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty payload: extreme timestamps, end of data on the closing byte, bad crc
      send_record('1, 32'd0, 32'd0, 0, 1'b0, 1'b0);
      send_record('0, 32'd0, 32'd0, 0, 1'b1, 1'b0);
      send_record(64'h0123_4567_89AB_CDEF, 32'd0, 32'd0, 0, 1'b0, 1'b1);
      // key only, value only, both, bad crc
      send_record({$urandom, $urandom}, 32'd1, 32'd0, 0, 1'b0, 1'b0);
      send_record({$urandom, $urandom}, 32'd0, 32'd1, 0, 1'b0, 1'b0);
      send_record({$urandom, $urandom}, 32'd3, 32'd4, 0, 1'b0, 1'b1);
      send_record({$urandom, $urandom}, 32'd2, 32'd5, 0, 1'b1, 1'b0);
      // header cut short
      send_record({$urandom, $urandom}, 32'd4, 32'd4, 1, 1'b1, 1'b0);
      send_record({$urandom, $urandom}, 32'd4, 32'd4, 19, 1'b1, 1'b0);
      send_record({$urandom, $urandom}, 32'd0, 32'd0, 19, 1'b1, 1'b0);
      // end of data on the last header byte with payload still owed
      send_record({$urandom, $urandom}, 32'd2, 32'd2, 20, 1'b1, 1'b0);
      // payload cut in the key and in the value
      send_record({$urandom, $urandom}, 32'd4, 32'd4, 22, 1'b1, 1'b0);
      send_record({$urandom, $urandom}, 32'd4, 32'd4, 26, 1'b1, 1'b0);
      send_record('1, '1, '1, 23, 1'b1, 1'b0);
      send_record('0, 32'h8000_0000, 32'h8000_0001, 21, 1'b1, 1'b1);

      run_phase(0, 0);
      run_phase(63, 0);
      run_phase(0, 63);
      run_phase(32, 32);

      push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== log_record_decoder_checker_top.f =====
src/lrdc_pkg.sv
src/lrdc_front.sv
src/lrdc_queue.sv
src/lrdc_back.sv
src/log_record_decoder_checker_top.sv
bench/lrdc_stream_monitor.sv
bench/tb_log_record_decoder_checker_top.sv
